/* rtl/lci_pkg.sv */
package lci_pkg;

  // default field geometry
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // digit size of the pipelined multipliers
  localparam int MUL_DIGIT = 34;

  // divider status flags
  typedef struct packed {
    logic rnz;  // nonzero remainder
    logic ovf;  // quotient does not fit
  } div_flags_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // number of multiplier digits for an operand of w bits
  function automatic int digits(input int w);
    return (w + MUL_DIGIT - 1) / MUL_DIGIT;
  endfunction

  // latency of lci_mul without padding: abs stage, one stage per digit pair, sign stage
  function automatic int mul_lat(input int wa, input int wb);
    return digits(wa) * digits(wb) + 2;
  endfunction

endpackage

/* rtl/lci_delay.sv */
module lci_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (N == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] sh_r [0:N-1];

      // shift line, advances with the pipeline
      always_ff @(posedge clk) begin
        if (en) begin
          sh_r[0] <= d;
          for (int i = 1; i < N; i++) begin
            sh_r[i] <= sh_r[i-1];
          end
        end
      end

      assign q = sh_r[N-1];
    end
  endgenerate

endmodule

/* rtl/lci_mul.sv */
module lci_mul #(
  parameter int WA  = 32,
  parameter int WB  = 32,
  parameter int LAT = 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int DG   = lci_pkg::MUL_DIGIT;
  localparam int NA   = lci_pkg::digits(WA);
  localparam int NB   = lci_pkg::digits(WB);
  localparam int NS   = NA * NB;
  localparam int AWF  = NA * DG;
  localparam int BWF  = NB * DG;
  localparam int PWF  = AWF + BWF;
  localparam int PADL = LAT - NS - 2;

  logic [WA-1:0]          amag;
  logic [WB-1:0]          bmag;
  logic [AWF-1:0]         am_r  [0:NS-1];
  logic [BWF-1:0]         bm_r  [0:NS-1];
  logic                   ng_r  [0:NS];
  logic [PWF-1:0]         acc_r [1:NS];
  logic [PWF-1:0]         acc_neg;
  logic signed [WA+WB-1:0] p_r;

  // magnitudes and product sign
  assign amag = a[WA-1] ? -a : a;
  assign bmag = b[WB-1] ? -b : b;

  always_ff @(posedge clk) begin
    if (en) begin
      am_r[0] <= AWF'(amag);
      bm_r[0] <= BWF'(bmag);
      ng_r[0] <= a[WA-1] ^ b[WB-1];
    end
  end

  // one digit-pair partial product per stage
  generate
    for (genvar s = 0; s < NS; s++) begin : g_pp
      localparam int IA = s / NB;
      localparam int IB = s % NB;
      logic [2*DG-1:0] pp;
      logic [PWF-1:0]  acc_in;

      assign pp = am_r[s][IA*DG +: DG] * bm_r[s][IB*DG +: DG];

      if (s == 0) begin : g_first
        assign acc_in = '0;
      end else begin : g_next
        assign acc_in = acc_r[s];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[s+1] <= acc_in + (PWF'(pp) << ((IA + IB) * DG));
          ng_r[s+1]  <= ng_r[s];
        end
      end

      if (s < NS - 1) begin : g_fwd
        always_ff @(posedge clk) begin
          if (en) begin
            am_r[s+1] <= am_r[s];
            bm_r[s+1] <= bm_r[s];
          end
        end
      end
    end
  endgenerate

  // restore the sign
  assign acc_neg = -acc_r[NS];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ng_r[NS] ? acc_neg[WA+WB-1:0] : acc_r[NS][WA+WB-1:0];
    end
  end

  // pad to the requested latency
  lci_delay #(.W(WA + WB), .N(PADL)) u_pad (
    .clk (clk),
    .en  (en),
    .d   (p_r),
    .q   (p)
  );

endmodule

/* rtl/lci_sqrt.sv */
module lci_sqrt #(
  parameter int WSQ = 132
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WSQ-1:0]   n,
  output logic [WSQ/2-1:0] root
);

  localparam int H = WSQ / 2;

  logic [WSQ-1:0] res_r [1:H];
  logic [WSQ-1:0] rem_r [1:H-1];

  // one root bit per stage, highest first
  generate
    for (genvar j = 0; j < H; j++) begin : g_stage
      localparam int K = H - 1 - j;
      localparam logic [WSQ-1:0] BITV = {{(WSQ-1){1'b0}}, 1'b1} << (2 * K);
      logic [WSQ-1:0] rem_in;
      logic [WSQ-1:0] res_in;
      logic [WSQ-1:0] trial;
      logic           ge;

      if (j == 0) begin : g_first
        assign rem_in = n;
        assign res_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[j];
        assign res_in = res_r[j];
      end

      assign trial = res_in + BITV;
      assign ge    = rem_in >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          res_r[j+1] <= ge ? ((res_in >> 1) + BITV) : (res_in >> 1);
        end
      end

      if (j < H - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[j+1] <= ge ? (rem_in - trial) : rem_in;
          end
        end
      end
    end
  endgenerate

  assign root = res_r[H][H-1:0];

endmodule

/* rtl/lci_div.sv */
module lci_div #(
  parameter int WN = 84,
  parameter int WA = 64,
  parameter int QB = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [WN-1:0]           n,
  input  logic [WA-1:0]           a,
  output logic [QB-1:0]           q,
  output lci_pkg::div_flags_t     flags
);

  localparam int WC = lci_pkg::imax(WN, WA + QB);

  logic [WN-1:0] rem_r [1:QB];
  logic [WA-1:0] a_r   [1:QB-1];
  logic [QB-1:0] q_r   [1:QB];
  logic          ov_r  [1:QB];
  logic          ovf0;

  // quotient too wide for QB bits
  assign ovf0 = WC'(n) >= (WC'(a) << QB);

  // restoring division, one quotient bit per stage
  generate
    for (genvar j = 0; j < QB; j++) begin : g_stage
      localparam int K = QB - 1 - j;
      localparam logic [QB-1:0] QBIT = {{(QB-1){1'b0}}, 1'b1} << K;
      logic [WN-1:0] rem_in;
      logic [WA-1:0] a_in;
      logic [QB-1:0] q_in;
      logic          ov_in;
      logic [WC-1:0] dv;
      logic [WC-1:0] diff;
      logic          ge;

      if (j == 0) begin : g_first
        assign rem_in = n;
        assign a_in   = a;
        assign q_in   = '0;
        assign ov_in  = ovf0;
      end else begin : g_next
        assign rem_in = rem_r[j];
        assign a_in   = a_r[j];
        assign q_in   = q_r[j];
        assign ov_in  = ov_r[j];
      end

      assign dv   = WC'(a_in) << K;
      assign ge   = WC'(rem_in) >= dv;
      assign diff = WC'(rem_in) - dv;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= ge ? diff[WN-1:0] : rem_in;
          q_r[j+1]   <= ge ? (q_in | QBIT) : q_in;
          ov_r[j+1]  <= ov_in;
        end
      end

      if (j < QB - 1) begin : g_fwd
        always_ff @(posedge clk) begin
          if (en) begin
            a_r[j+1] <= a_in;
          end
        end
      end
    end
  endgenerate

  assign q         = q_r[QB];
  assign flags.rnz = |rem_r[QB];
  assign flags.ovf = ov_r[QB];

endmodule

/* rtl/line_circle_intersection_unit.sv */
// Channel  Dir  Ports                              Transaction
// in       in   in_tvalid in_tready in_tdata       one line and circle query
// out      out  out_tvalid out_tready out_tdata    one intersection result
//               out_tuser
//
// While the output does not stall, a new query is taken every cycle and results
// leave in order one per cycle. The pipeline depth is set mostly by the square
// root (one root bit per stage, 2*COORD_WIDTH+2 stages) and the dividers (one
// quotient bit per stage, COORD_WIDTH+1 stages).
// Reset clears only the valid pipeline; data registers are not reset.
// The whole pipeline holds while a result waits: in_tready = !out_tvalid || out_tready.
module line_circle_intersection_unit #(
  parameter int COORD_WIDTH = lci_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lci_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((7 * COORD_WIDTH - 1 + 7) / 8) * 8,
  localparam int OUT_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // line_x, line_y, dir_x, dir_y, center_x, center_y, radius
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // near_param, far_param, near_x, near_y, far_x, far_y
  output logic [OUT_W-1:0] out_tdata,
  // hit
  output logic             out_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int QW   = CW + 1;
  localparam int AWID = 2 * CW + 1;
  localparam int BW   = 2 * CW + 2;
  localparam int CWID = 2 * CW + 3;
  localparam int DWID = 4 * CW + 5;
  localparam int WSQ  = 4 * CW + 4;
  localparam int RW   = WSQ / 2;
  localparam int NUMW = 2 * CW + 4;
  localparam int XPW  = CW + NUMW;
  localparam int WN   = lci_pkg::imax(NUMW + FRAC_BITS, XPW);
  localparam int QB   = CW + 1;
  localparam int ADW  = 2 * CW;
  localparam int SW   = QB + 3;

  localparam int L1 = lci_pkg::mul_lat(QW, QW);
  localparam int L2 = lci_pkg::imax(lci_pkg::mul_lat(BW, BW), lci_pkg::mul_lat(AWID, CWID));
  localparam int L3 = lci_pkg::mul_lat(CW, NUMW);
  localparam int LS = RW;

  // register positions along the pipeline
  localparam int T2 = L1 + 1;
  localparam int T4 = T2 + L2 + 1;
  localparam int T5 = T4 + LS;
  localparam int T6 = T5 + 1;
  localparam int T7 = T6 + L3;
  localparam int T8 = T7 + 1;
  localparam int T9 = T8 + QB;
  localparam int NV = T9 + 2;

  localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = ~MAXV;
  localparam logic [CW-1:0] MAXC = MAXV[CW-1:0];
  localparam logic [CW-1:0] MINC = MINV[CW-1:0];

  logic en;
  logic [NV-1:0] vld_r;

  logic signed [CW-1:0] px_r, py_r, vx_r, vy_r, kx_r, ky_r;
  logic [CW-2:0]        rad_r;
  logic signed [CW-1:0] rr;
  logic signed [QW-1:0] qx, qy;

  logic signed [2*CW-1:0] vxx, vyy, rsq;
  logic signed [2*CW:0]   vqx, vqy;
  logic signed [2*QW-1:0] qxx, qyy;

  logic signed [AWID-1:0] a_r;
  logic signed [BW-1:0]   b_r;
  logic signed [CWID-1:0] c_r;

  logic signed [2*BW-1:0]      bb;
  logic signed [AWID+CWID-1:0] ac;
  logic signed [DWID-1:0]      d_r;
  logic                        hit;

  logic [RW-1:0]          root_w;
  logic signed [BW-1:0]   b_d;
  logic signed [NUMW-1:0] sd_x, nb;
  logic signed [NUMW-1:0] num0_r, num1_r, num0_d, num1_d;
  logic signed [CW-1:0]   vx_d, vy_d, px_d, py_d;
  logic signed [XPW-1:0]  x0, y0, x1, y1;
  logic [ADW-1:0]         a_d;

  logic signed [WN-1:0]   src [0:5];
  logic [WN-1:0]          dn_r [0:5];
  logic [5:0]             dneg_r, dneg_d;
  logic [QB-1:0]          q_w  [0:5];
  lci_pkg::div_flags_t    fl_w [0:5];
  logic                   hit_d;
  logic [CW-1:0]          res_r [0:5];
  logic                   hit_o_r;

  // global advance: hold everything while the output stalls
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_tvalid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= in_tdata[0*CW +: CW];
      py_r  <= in_tdata[1*CW +: CW];
      vx_r  <= in_tdata[2*CW +: CW];
      vy_r  <= in_tdata[3*CW +: CW];
      kx_r  <= in_tdata[4*CW +: CW];
      ky_r  <= in_tdata[5*CW +: CW];
      rad_r <= in_tdata[6*CW +: CW-1];
    end
  end

  assign qx = QW'(px_r) - QW'(kx_r);
  assign qy = QW'(py_r) - QW'(ky_r);
  assign rr = {1'b0, rad_r};

  // first products
  lci_mul #(.WA(CW), .WB(CW), .LAT(L1)) u_vxx (.clk, .en, .a(vx_r), .b(vx_r), .p(vxx));
  lci_mul #(.WA(CW), .WB(CW), .LAT(L1)) u_vyy (.clk, .en, .a(vy_r), .b(vy_r), .p(vyy));
  lci_mul #(.WA(CW), .WB(QW), .LAT(L1)) u_vqx (.clk, .en, .a(vx_r), .b(qx), .p(vqx));
  lci_mul #(.WA(CW), .WB(QW), .LAT(L1)) u_vqy (.clk, .en, .a(vy_r), .b(qy), .p(vqy));
  lci_mul #(.WA(QW), .WB(QW), .LAT(L1)) u_qxx (.clk, .en, .a(qx), .b(qx), .p(qxx));
  lci_mul #(.WA(QW), .WB(QW), .LAT(L1)) u_qyy (.clk, .en, .a(qy), .b(qy), .p(qyy));
  lci_mul #(.WA(CW), .WB(CW), .LAT(L1)) u_rsq (.clk, .en, .a(rr), .b(rr), .p(rsq));

  // quadratic coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= AWID'(vxx) + AWID'(vyy);
      b_r <= BW'(vqx) + BW'(vqy);
      c_r <= CWID'(qxx) + CWID'(qyy) - CWID'(rsq);
    end
  end

  // discriminant
  lci_mul #(.WA(BW), .WB(BW), .LAT(L2)) u_bb (.clk, .en, .a(b_r), .b(b_r), .p(bb));
  lci_mul #(.WA(AWID), .WB(CWID), .LAT(L2)) u_ac (.clk, .en, .a(a_r), .b(c_r), .p(ac));

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= DWID'(bb) - DWID'(ac);
    end
  end

  assign hit = !d_r[DWID-1] && (|d_r);

  lci_sqrt #(.WSQ(WSQ)) u_sqrt (.clk, .en, .n(d_r[WSQ-1:0]), .root(root_w));

  lci_delay #(.W(BW), .N(T5 - T2)) u_dly_b (.clk, .en, .d(b_r), .q(b_d));

  // numerators -B -/+ sqrt(D)
  assign sd_x = NUMW'(root_w);
  assign nb   = -NUMW'(b_d);

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= nb - sd_x;
      num1_r <= nb + sd_x;
    end
  end

  lci_delay #(.W(CW), .N(T6)) u_dly_vx (.clk, .en, .d(vx_r), .q(vx_d));
  lci_delay #(.W(CW), .N(T6)) u_dly_vy (.clk, .en, .d(vy_r), .q(vy_d));

  // direction times numerators
  lci_mul #(.WA(CW), .WB(NUMW), .LAT(L3)) u_x0 (.clk, .en, .a(vx_d), .b(num0_r), .p(x0));
  lci_mul #(.WA(CW), .WB(NUMW), .LAT(L3)) u_y0 (.clk, .en, .a(vy_d), .b(num0_r), .p(y0));
  lci_mul #(.WA(CW), .WB(NUMW), .LAT(L3)) u_x1 (.clk, .en, .a(vx_d), .b(num1_r), .p(x1));
  lci_mul #(.WA(CW), .WB(NUMW), .LAT(L3)) u_y1 (.clk, .en, .a(vy_d), .b(num1_r), .p(y1));

  lci_delay #(.W(NUMW), .N(L3)) u_dly_n0 (.clk, .en, .d(num0_r), .q(num0_d));
  lci_delay #(.W(NUMW), .N(L3)) u_dly_n1 (.clk, .en, .d(num1_r), .q(num1_d));

  // dividends in output order
  always_comb begin
    src[0] = WN'(num0_d) <<< FRAC_BITS;
    src[1] = WN'(num1_d) <<< FRAC_BITS;
    src[2] = WN'(x0);
    src[3] = WN'(y0);
    src[4] = WN'(x1);
    src[5] = WN'(y1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        dn_r[l]   <= src[l][WN-1] ? -src[l] : src[l];
        dneg_r[l] <= src[l][WN-1];
      end
    end
  end

  lci_delay #(.W(ADW), .N(T8 - T2)) u_dly_a (.clk, .en, .d(a_r[ADW-1:0]), .q(a_d));
  lci_delay #(.W(6), .N(QB)) u_dly_neg (.clk, .en, .d(dneg_r), .q(dneg_d));
  lci_delay #(.W(1), .N(T9 - T4)) u_dly_hit (.clk, .en, .d(hit), .q(hit_d));
  lci_delay #(.W(CW), .N(T9)) u_dly_px (.clk, .en, .d(px_r), .q(px_d));
  lci_delay #(.W(CW), .N(T9)) u_dly_py (.clk, .en, .d(py_r), .q(py_d));

  // division, floor, offset, saturation and miss zeroing per lane
  generate
    for (genvar l = 0; l < 6; l++) begin : g_lane
      logic signed [CW-1:0]   base;
      logic signed [QB+1:0]   qz;
      logic signed [QB+1:0]   qs;
      logic signed [SW-1:0]   sum;
      logic [CW-1:0]          val;

      lci_div #(.WN(WN), .WA(ADW), .QB(QB)) u_div (
        .clk   (clk),
        .en    (en),
        .n     (dn_r[l]),
        .a     (a_d),
        .q     (q_w[l]),
        .flags (fl_w[l])
      );

      if (l == 2 || l == 4) begin : g_bx
        assign base = px_d;
      end else if (l == 3 || l == 5) begin : g_by
        assign base = py_d;
      end else begin : g_b0
        assign base = '0;
      end

      assign qz  = {2'b00, q_w[l]};
      assign qs  = dneg_d[l] ? (-qz - (QB+2)'(fl_w[l].rnz)) : qz;
      assign sum = SW'(base) + SW'(qs);

      always_comb begin
        if (!hit_d) begin
          val = '0;
        end else if (fl_w[l].ovf) begin
          val = dneg_d[l] ? MINC : MAXC;
        end else if (sum > MAXV) begin
          val = MAXC;
        end else if (sum < MINV) begin
          val = MINC;
        end else begin
          val = sum[CW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          res_r[l] <= val;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      hit_o_r <= hit_d;
    end
  end

  assign out_tdata = OUT_W'({res_r[5], res_r[4], res_r[3], res_r[2], res_r[1], res_r[0]});
  assign out_tuser = hit_o_r;

  // no hit means all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries nonzero data");

  // near parameter never exceeds far parameter
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      $signed(out_tdata[CW-1:0]) <= $signed(out_tdata[2*CW-1:CW]))
    else $error("near parameter above far parameter");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid result right after reset");

endmodule
